// File: rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

   // Field widths fixed by the channel format
   localparam int unsigned MAX_BUFFERS_DEF = 32;
   localparam int unsigned POOL_W          = 6;
   localparam int unsigned OP_W            = 2;
   localparam int unsigned BID_W           = 8;
   localparam int unsigned STATUS_W        = 2;
   localparam int unsigned RID_W           = 5;
   localparam int unsigned CNT_OUT_W       = 6;
   localparam int unsigned EVT_W           = 32;
   localparam int unsigned BUF_ST_W        = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_MARK    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_SCAN    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE        = 2'd0,
      RSP_ACQ_FAIL    = 2'd1,
      RSP_BAD_ID      = 2'd2,
      RSP_WRONG_STATE = 2'd3
   } rsp_status_type;

   typedef enum logic [BUF_ST_W-1:0] {
      BUF_FREE   = 2'd0,
      BUF_USE    = 2'd1,
      BUF_FLIGHT = 2'd2
   } buf_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SCAN_END
   } fsm_state_type;

   // Per-memory control bundle
   typedef struct packed {
      logic init;
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// File: rtl/bpm_channels.sv
`default_nettype none

interface bpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [bpm_pkg::OP_W-1:0]    op;
   logic [bpm_pkg::BID_W-1:0]   target_id;

   modport source (output valid, op, target_id, input ready);
   modport sink   (input valid, op, target_id, output ready);
endinterface

interface bpm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bpm_pkg::STATUS_W-1:0]    status;
   logic [bpm_pkg::RID_W-1:0]       result_id;
   logic                            id_valid;
   logic [bpm_pkg::CNT_OUT_W-1:0]   in_use_count;
   logic [bpm_pkg::CNT_OUT_W-1:0]   transit_count;
   logic [bpm_pkg::CNT_OUT_W-1:0]   available_count;
   logic [bpm_pkg::CNT_OUT_W-1:0]   peak_in_use;
   logic [bpm_pkg::CNT_OUT_W-1:0]   peak_in_flight;
   logic [bpm_pkg::EVT_W-1:0]       acquire_total;
   logic [bpm_pkg::EVT_W-1:0]       acquire_failures;
   logic [bpm_pkg::EVT_W-1:0]       release_total;
   logic                            last;

   modport source (output valid, status, result_id, id_valid, in_use_count,
                   transit_count, available_count, peak_in_use, peak_in_flight,
                   acquire_total, acquire_failures, release_total, last,
                   input ready);
   modport sink   (input valid, status, result_id, id_valid, in_use_count,
                   transit_count, available_count, peak_in_use, peak_in_flight,
                   acquire_total, acquire_failures, release_total, last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/buffer_pool_manager.sv
`default_nettype none

// Channel  Dir  Handshake     Payload
// req_chan in   valid/ready   op, target_id
// rsp_chan out  valid/ready   status, result_id, id_valid, counts, peaks, event counters, last
// csr_*    in   csr_wr_en     csr_wr_data = pool_count (any write re-inits the pool)
//
// Acquire, mark and release read the free queue and state memories when accepted in
// S_IDLE (registered read), then update, write back and load the response in S_EXEC.
// A leak scan steps through accept, dispatch, a read then a check for every id of
// the pool, and a final state that loads the last response.
// Reset and pool_count writes re-init: valid bits in both memories are cleared.
// A response waits in the output register; work stalls if a new one must load while
// the old one is still pending, and a scan dispatch also waits for it to drain.
module buffer_pool_manager #(
   parameter int unsigned MAX_BUFFERS = bpm_pkg::MAX_BUFFERS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   bpm_req_if.sink                           req_chan,
   bpm_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [bpm_pkg::POOL_W-1:0]   csr_wr_data
);
   localparam int unsigned IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BUFFERS + 1);
   localparam logic [6:0]       MAX7     = 7'(MAX_BUFFERS);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BUFFERS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [bpm_pkg::EVT_W-1:0] EVT_ONE = bpm_pkg::EVT_W'(1);

   // control state
   bpm_pkg::fsm_state_type         state_ff, state_in;
   logic [bpm_pkg::POOL_W-1:0]     pool_ff, pool_in;
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [IDX_W-1:0]               tail_ff, tail_in;
   logic [CNT_W-1:0]               free_ff, free_in;
   logic [CNT_W-1:0]               busy_ff, busy_in;
   logic [CNT_W-1:0]               flight_ff, flight_in;
   logic [CNT_W-1:0]               busy_peak_ff, busy_peak_in;
   logic [CNT_W-1:0]               flight_peak_ff, flight_peak_in;
   logic [bpm_pkg::EVT_W-1:0]      acq_total_ff, acq_total_in;
   logic [bpm_pkg::EVT_W-1:0]      acq_fail_ff, acq_fail_in;
   logic [bpm_pkg::EVT_W-1:0]      rel_total_ff, rel_total_in;
   logic [IDX_W-1:0]               scan_idx_ff, scan_idx_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // transaction payload (no reset needed)
   bpm_pkg::op_type                op_ff, op_in;
   logic [bpm_pkg::BID_W-1:0]      bid_ff, bid_in;
   logic [IDX_W-1:0]               pend_ff, pend_in;
   logic [bpm_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bpm_pkg::RID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                           rsp_idv_ff, rsp_idv_in;
   logic                           rsp_last_ff, rsp_last_in;

   // memory ports
   bpm_pkg::mem_ctl_type           q_ctl, s_ctl;
   logic [IDX_W-1:0]               q_rd_addr, q_rd_data, q_wr_addr, q_wr_data;
   logic [IDX_W-1:0]               s_rd_addr, s_wr_addr;
   logic [bpm_pkg::BUF_ST_W-1:0]   s_rd_data, s_wr_data;

   // helpers
   logic [6:0]                     pool_n7, csr_n7;
   logic [CNT_W-1:0]               n_act;
   logic                           rsp_free, rsp_load;
   logic                           bad_id, leaked;
   logic [CNT_W-1:0]               busy_inc, flight_inc;

   assign pool_n7  = ({1'b0, pool_ff} > MAX7) ? MAX7 : {1'b0, pool_ff};
   assign csr_n7   = ({1'b0, csr_wr_data} > MAX7) ? MAX7 : {1'b0, csr_wr_data};
   assign n_act    = CNT_W'(pool_n7);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign bad_id   = (n_act == '0) || (bid_ff >= {1'b0, pool_n7});
   assign leaked   = (s_rd_data != bpm_pkg::BUF_FREE);
   assign busy_inc   = busy_ff + CNT_ONE;
   assign flight_inc = flight_ff + CNT_ONE;

   bpm_free_queue #(
      .DEPTH (MAX_BUFFERS)
   ) u_free_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data)
   );

   bpm_status_mem #(
      .DEPTH (MAX_BUFFERS)
   ) u_status_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (s_ctl),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data)
   );

   always_comb begin
      state_in       = state_ff;
      pool_in        = pool_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      free_in        = free_ff;
      busy_in        = busy_ff;
      flight_in      = flight_ff;
      busy_peak_in   = busy_peak_ff;
      flight_peak_in = flight_peak_ff;
      acq_total_in   = acq_total_ff;
      acq_fail_in    = acq_fail_ff;
      rel_total_in   = rel_total_ff;
      scan_idx_in    = scan_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      op_in          = op_ff;
      bid_in         = bid_ff;

      q_ctl       = '0;
      q_ctl.init  = csr_wr_en;
      q_rd_addr   = head_ff;
      q_wr_addr   = tail_ff;
      q_wr_data   = bid_ff[IDX_W-1:0];
      s_ctl       = '0;
      s_ctl.init  = csr_wr_en;
      s_rd_addr   = req_chan.target_id[IDX_W-1:0];
      s_wr_addr   = bid_ff[IDX_W-1:0];
      s_wr_data   = bpm_pkg::BUF_FREE;

      rsp_load      = 1'b0;
      rsp_status_in = bpm_pkg::RSP_DONE;
      rsp_id_in     = '0;
      rsp_idv_in    = 1'b0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         bpm_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in        = bpm_pkg::op_type'(req_chan.op);
               bid_in       = req_chan.target_id;
               q_ctl.rd_en  = 1'b1;
               s_ctl.rd_en  = 1'b1;
               state_in     = bpm_pkg::S_EXEC;
            end
         end

         bpm_pkg::S_EXEC: begin
            if (rsp_free) begin
               state_in = bpm_pkg::S_IDLE;
               unique case (op_ff)
                  bpm_pkg::OP_ACQUIRE: begin
                     rsp_load     = 1'b1;
                     acq_total_in = acq_total_ff + EVT_ONE;
                     if (n_act == '0 || free_ff == '0) begin
                        acq_fail_in   = acq_fail_ff + EVT_ONE;
                        rsp_status_in = bpm_pkg::RSP_ACQ_FAIL;
                     end else begin
                        head_in     = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_ONE;
                        free_in     = free_ff - CNT_ONE;
                        busy_in     = busy_inc;
                        if (busy_inc > busy_peak_ff) begin
                           busy_peak_in = busy_inc;
                        end
                        s_ctl.wr_en = 1'b1;
                        s_wr_addr   = q_rd_data;
                        s_wr_data   = bpm_pkg::BUF_USE;
                        rsp_id_in   = bpm_pkg::RID_W'(q_rd_data);
                        rsp_idv_in  = 1'b1;
                     end
                  end
                  bpm_pkg::OP_MARK: begin
                     rsp_load = 1'b1;
                     if (bad_id) begin
                        rsp_status_in = bpm_pkg::RSP_BAD_ID;
                     end else if (s_rd_data != bpm_pkg::BUF_USE) begin
                        rsp_status_in = bpm_pkg::RSP_WRONG_STATE;
                     end else begin
                        s_ctl.wr_en = 1'b1;
                        s_wr_data   = bpm_pkg::BUF_FLIGHT;
                        busy_in     = (busy_ff != '0) ? busy_ff - CNT_ONE : busy_ff;
                        flight_in   = flight_inc;
                        if (flight_inc > flight_peak_ff) begin
                           flight_peak_in = flight_inc;
                        end
                     end
                  end
                  bpm_pkg::OP_RELEASE: begin
                     rsp_load = 1'b1;
                     if (bad_id) begin
                        rsp_status_in = bpm_pkg::RSP_BAD_ID;
                     end else if (s_rd_data == bpm_pkg::BUF_FREE) begin
                        // already free: do not queue it twice
                        rsp_status_in = bpm_pkg::RSP_WRONG_STATE;
                     end else begin
                        if (s_rd_data == bpm_pkg::BUF_FLIGHT) begin
                           flight_in = (flight_ff != '0) ? flight_ff - CNT_ONE : flight_ff;
                        end else begin
                           busy_in = (busy_ff != '0) ? busy_ff - CNT_ONE : busy_ff;
                        end
                        s_ctl.wr_en  = 1'b1;
                        s_wr_data    = bpm_pkg::BUF_FREE;
                        q_ctl.wr_en  = 1'b1;
                        tail_in      = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_ONE;
                        free_in      = free_ff + CNT_ONE;
                        rel_total_in = rel_total_ff + EVT_ONE;
                     end
                  end
                  bpm_pkg::OP_SCAN: begin
                     if (n_act == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = bpm_pkg::RSP_BAD_ID;
                     end else begin
                        scan_idx_in   = '0;
                        pend_valid_in = 1'b0;
                        state_in      = bpm_pkg::S_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = bpm_pkg::S_IDLE;
                  end
               endcase
            end
         end

         bpm_pkg::S_SCAN_RD: begin
            s_ctl.rd_en = 1'b1;
            s_rd_addr   = scan_idx_ff;
            state_in    = bpm_pkg::S_SCAN_CHK;
         end

         bpm_pkg::S_SCAN_CHK: begin
            // a leaked id is held back one step so the final one can carry last
            if (!(leaked && pend_valid_ff && !rsp_free)) begin
               if (leaked) begin
                  if (pend_valid_ff) begin
                     rsp_load    = 1'b1;
                     rsp_id_in   = bpm_pkg::RID_W'(pend_ff);
                     rsp_idv_in  = 1'b1;
                     rsp_last_in = 1'b0;
                  end
                  pend_in       = scan_idx_ff;
                  pend_valid_in = 1'b1;
               end
               if (CNT_W'(scan_idx_ff) == n_act - CNT_ONE) begin
                  state_in = bpm_pkg::S_SCAN_END;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_ONE;
                  state_in    = bpm_pkg::S_SCAN_RD;
               end
            end
         end

         bpm_pkg::S_SCAN_END: begin
            if (rsp_free) begin
               rsp_load   = 1'b1;
               rsp_id_in  = pend_valid_ff ? bpm_pkg::RID_W'(pend_ff) : '0;
               rsp_idv_in = pend_valid_ff;
               state_in   = bpm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bpm_pkg::S_IDLE;
         end
      endcase

      // pool (re)init: queue holds 0..n-1, all stats cleared
      if (csr_wr_en) begin
         pool_in        = csr_wr_data;
         head_in        = '0;
         tail_in        = (csr_n7 == MAX7) ? '0 : IDX_W'(csr_n7);
         free_in        = CNT_W'(csr_n7);
         busy_in        = '0;
         flight_in      = '0;
         busy_peak_in   = '0;
         flight_peak_in = '0;
         acq_total_in   = '0;
         acq_fail_in    = '0;
         rel_total_in   = '0;
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bpm_pkg::S_IDLE;
         pool_ff        <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         free_ff        <= '0;
         busy_ff        <= '0;
         flight_ff      <= '0;
         busy_peak_ff   <= '0;
         flight_peak_ff <= '0;
         acq_total_ff   <= '0;
         acq_fail_ff    <= '0;
         rel_total_ff   <= '0;
         scan_idx_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pool_ff        <= pool_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         free_ff        <= free_in;
         busy_ff        <= busy_in;
         flight_ff      <= flight_in;
         busy_peak_ff   <= busy_peak_in;
         flight_peak_ff <= flight_peak_in;
         acq_total_ff   <= acq_total_in;
         acq_fail_ff    <= acq_fail_in;
         rel_total_ff   <= rel_total_in;
         scan_idx_ff    <= scan_idx_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      bid_ff <= bid_in;
      pend_ff <= pend_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_idv_ff    <= rsp_idv_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign req_chan.ready = (state_ff == bpm_pkg::S_IDLE);

   // counters move only when a response loads or on a pool_count write, so between writes they track the held response
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.result_id        = rsp_id_ff;
   assign rsp_chan.id_valid         = rsp_idv_ff;
   assign rsp_chan.last             = rsp_last_ff;
   assign rsp_chan.in_use_count     = bpm_pkg::CNT_OUT_W'(busy_ff);
   assign rsp_chan.transit_count    = bpm_pkg::CNT_OUT_W'(flight_ff);
   assign rsp_chan.available_count  = bpm_pkg::CNT_OUT_W'(free_ff);
   assign rsp_chan.peak_in_use      = bpm_pkg::CNT_OUT_W'(busy_peak_ff);
   assign rsp_chan.peak_in_flight   = bpm_pkg::CNT_OUT_W'(flight_peak_ff);
   assign rsp_chan.acquire_total    = acq_total_ff;
   assign rsp_chan.acquire_failures = acq_fail_ff;
   assign rsp_chan.release_total    = rel_total_ff;

   // every buffer of the pool is in exactly one of free / in use / in flight
   a_count_conserved: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 2)'(free_ff) + (CNT_W + 2)'(busy_ff) + (CNT_W + 2)'(flight_ff))
         == (CNT_W + 2)'(n_act))
      else $error("pool occupancy counts do not add up");

   a_peaks: assert property (@(posedge clock) disable iff (reset)
      (busy_peak_ff >= busy_ff) && (flight_peak_ff >= flight_ff))
      else $error("peak below current count");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s_ctl.rd_en && s_ctl.wr_en) && !(q_ctl.rd_en && q_ctl.wr_en))
      else $error("memory read and write in the same cycle");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !csr_wr_en) |=> (state_ff == bpm_pkg::S_EXEC))
      else $error("accepted transaction not executed");

endmodule

`default_nettype wire

// File: rtl/bpm_free_queue.sv
`default_nettype none

// Free-id ring storage. Entries not written since init read back as
// their own index, which is the initial fill 0..n-1.
module bpm_free_queue #(
   parameter  int unsigned DEPTH = bpm_pkg::MAX_BUFFERS_DEF,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bpm_pkg::mem_ctl_type         ctl,
   input  wire logic [IDX_W-1:0]             rd_addr,
   output logic [IDX_W-1:0]                  rd_data,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire logic [IDX_W-1:0]             wr_data
);
   logic [IDX_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [IDX_W-1:0] rd_raw_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic             rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff  <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
         rd_hit_ff  <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         written_ff <= '0;
      end else if (ctl.wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_hit_ff ? rd_raw_ff : rd_addr_ff;

endmodule

`default_nettype wire

// File: rtl/bpm_status_mem.sv
`default_nettype none

// Per-buffer state storage; unwritten entries read as free.
module bpm_status_mem #(
   parameter  int unsigned DEPTH = bpm_pkg::MAX_BUFFERS_DEF,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bpm_pkg::mem_ctl_type               ctl,
   input  wire logic [IDX_W-1:0]                   rd_addr,
   output logic [bpm_pkg::BUF_ST_W-1:0]            rd_data,
   input  wire logic [IDX_W-1:0]                   wr_addr,
   input  wire logic [bpm_pkg::BUF_ST_W-1:0]       wr_data
);
   logic [bpm_pkg::BUF_ST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]             written_ff;
   logic [bpm_pkg::BUF_ST_W-1:0] rd_raw_ff;
   logic                         rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff <= mem[rd_addr];
         rd_hit_ff <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         written_ff <= '0;
      end else if (ctl.wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_hit_ff ? rd_raw_ff : bpm_pkg::BUF_FREE;

endmodule

`default_nettype wire
